FILE: rtl/pfcc_pkg.sv
package pfcc_pkg;

	// Result kinds carried on the master-side tuser
	typedef enum logic [1:0] {
		ACT_WAIT     = 2'd0,
		ACT_SPURIOUS = 2'd1,
		ACT_ABORT    = 2'd2,
		ACT_DONE     = 2'd3
	} action_t;

	localparam int CHAN_W   = 2;
	localparam int COUNT_W  = 13;
	localparam int PIXEL_W  = 11;
	localparam int FRAMES_W = 32;
	localparam int MASK_W   = 8;
	localparam int NUM_REGS = 4;
	localparam int REG_IDX_W = 2;

	// Feeds that exist; trigger bits at and above this are dropped
	localparam int FEEDS = 8;
	localparam logic [MASK_W-1:0] FEED_KEEP =
		(FEEDS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << FEEDS) - 1);

	// Divide by three for values below 2^16: q = (x * 43691) >> 17
	localparam int DIV_W = 16;
	localparam logic [DIV_W-1:0] DIV3_RECIP = 16'd43691;
	localparam int DIV3_SHIFT = 17;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 72;

	typedef struct packed {
		logic [COUNT_W-1:0] dma_byte_count;
		logic               fifo_empty;
		logic               dma_busy;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0]   feed_trigger;
		logic [FRAMES_W-1:0] frames_done;
		logic                is_rgbw;
		logic [PIXEL_W-1:0]  frame_pixels;
		logic [COUNT_W-1:0]  frame_bytes;
		logic                fifo_flushed;
	} out_item_t;

endpackage

FILE: rtl/pixel_frame_capture_control.sv
// Frame capture control: one decision per end-of-frame event.
// Slave channel (s_*): s_tuser = channel, s_tdata = busy, FIFO empty and
// DMA byte count. Master channel (m_*): m_tuser = action, m_tdata = the
// frame report (flush flag, bytes, pixels, RGBW flag, frame count, feeds).
// Each accepted event yields exactly one result, in order.
// m_tvalid rises once an accepted request has passed an input register, then
// the per-channel state lookup, update and divide-by-three into the output
// register. One event per cycle is sustained while m_tready stays high; the
// rate is set by that single per-channel read-modify-write stage.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more event; s_tready drops only once
// both are full, and rises again in the cycle m_tready returns.
// Feed masks are written via cfg_we/cfg_index/cfg_data; the user must do so only
// while idle, as the block does not enforce it. Reset clears the abort flags and
// frame counters, sets every captured byte count to BUFFER_BYTES, clears the feed
// masks and empties both registers; no setup pass is needed afterwards.
module pixel_frame_capture_control #(
	parameter int BUFFER_BYTES = 4096,
	parameter int CHANNELS     = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [0] dma_busy, [1] fifo_empty, [14:2] dma_byte_count, [15] zero
	input  logic [pfcc_pkg::S_TDATA_W-1:0]       s_tdata,
	// [1:0] channel
	input  logic [pfcc_pkg::CHAN_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] fifo_flushed, [13:1] frame_bytes, [24:14] frame_pixels,
	// [25] is_rgbw, [57:26] frames_done, [65:58] feed_trigger, [71:66] zero
	output logic [pfcc_pkg::M_TDATA_W-1:0]       m_tdata,
	// [1:0] action
	output logic [1:0]                           m_tuser,
	input  logic                                 cfg_we,
	input  logic [pfcc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [pfcc_pkg::MASK_W-1:0]          cfg_data
);

	localparam int BUF_BITS = $clog2(BUFFER_BYTES + 1);
	localparam int CAP_W    = (BUF_BITS > pfcc_pkg::COUNT_W) ? BUF_BITS : pfcc_pkg::COUNT_W;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CAP_W-1:0] BUF_VAL = CAP_W'(BUFFER_BYTES);
	localparam logic [pfcc_pkg::CHAN_W:0] CH_LIMIT = (pfcc_pkg::CHAN_W + 1)'(CHANNELS);

	// feed masks
	logic [pfcc_pkg::MASK_W-1:0] feed_mask_q [pfcc_pkg::NUM_REGS];

	// per-channel state
	logic                          abort_q [CHANNELS];
	logic [CAP_W-1:0]              cap_q   [CHANNELS];
	logic [pfcc_pkg::FRAMES_W-1:0] cnt_q   [CHANNELS];

	// input register
	logic                        valid_s1;
	logic [pfcc_pkg::CHAN_W-1:0] chan_s1;
	pfcc_pkg::in_item_t          item_s1;

	// output register
	logic                 valid_s2;
	pfcc_pkg::action_t    action_s2;
	pfcc_pkg::out_item_t  res_s2;

	logic adv;
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pfcc_pkg::NUM_REGS; i++) begin
				feed_mask_q[i] <= '0;
			end
		end else if (cfg_we) begin
			feed_mask_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			chan_s1 <= s_tuser;
			item_s1 <= s_tdata[$bits(pfcc_pkg::in_item_t)-1:0];
		end
	end

	// decision for the event in the input register
	logic [IDX_W-1:0]              idx;
	logic                          ch_ok;
	logic                          ap;
	logic [CAP_W-1:0]              cap;
	logic [pfcc_pkg::FRAMES_W-1:0] cnt_next;
	logic [CAP_W-1:0]              count_sat;
	logic [pfcc_pkg::DIV_W-1:0]    bytes16;
	logic [2*pfcc_pkg::DIV_W-1:0]  prod;
	logic [pfcc_pkg::DIV_W-1:0]    third;
	logic [pfcc_pkg::DIV_W-1:0]    rem3;
	logic                          rgbw;
	logic [pfcc_pkg::DIV_W-1:0]    pixels;
	logic                          do_capture;
	logic                          do_done;
	pfcc_pkg::action_t             action_c;
	pfcc_pkg::out_item_t           res_c;

	always_comb begin
		idx       = chan_s1[IDX_W-1:0];
		ch_ok     = {1'b0, chan_s1} < CH_LIMIT;
		ap        = abort_q[idx];
		cap       = cap_q[idx];
		cnt_next  = cnt_q[idx] + 32'd1;
		count_sat = (CAP_W'(item_s1.dma_byte_count) > BUF_VAL) ? BUF_VAL
			: CAP_W'(item_s1.dma_byte_count);

		bytes16 = pfcc_pkg::DIV_W'(cap);
		prod    = (2*pfcc_pkg::DIV_W)'(bytes16) * (2*pfcc_pkg::DIV_W)'(pfcc_pkg::DIV3_RECIP);
		third   = pfcc_pkg::DIV_W'(prod >> pfcc_pkg::DIV3_SHIFT);
		rem3    = bytes16 - pfcc_pkg::DIV_W'(third * 16'd3);
		rgbw    = (rem3 != '0) && (bytes16[1:0] == 2'b00);
		pixels  = rgbw ? (bytes16 >> 2) : third;

		do_capture = 1'b0;
		do_done    = 1'b0;
		action_c   = pfcc_pkg::ACT_WAIT;
		res_c      = '0;
		if (ch_ok) begin
			if (item_s1.dma_busy) begin
				if (item_s1.fifo_empty && !ap) begin
					if (item_s1.dma_byte_count == '0) begin
						action_c = pfcc_pkg::ACT_SPURIOUS;
					end else begin
						action_c   = pfcc_pkg::ACT_ABORT;
						do_capture = 1'b1;
					end
				end
				res_c.frames_done = cnt_q[idx];
			end else begin
				action_c           = pfcc_pkg::ACT_DONE;
				do_done            = 1'b1;
				res_c.fifo_flushed = !item_s1.fifo_empty;
				res_c.frame_bytes  = cap[pfcc_pkg::COUNT_W-1:0];
				res_c.frame_pixels = pixels[pfcc_pkg::PIXEL_W-1:0];
				res_c.is_rgbw      = rgbw;
				res_c.frames_done  = cnt_next;
				res_c.feed_trigger = feed_mask_q[chan_s1] & pfcc_pkg::FEED_KEEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				abort_q[i] <= 1'b0;
				cap_q[i]   <= BUF_VAL;
				cnt_q[i]   <= '0;
			end
		end else if (adv) begin
			if (do_capture) begin
				abort_q[idx] <= 1'b1;
				cap_q[idx]   <= count_sat;
			end
			if (do_done) begin
				// clear the abort flag only when the FIFO drained on its own
				if (item_s1.fifo_empty) begin
					abort_q[idx] <= 1'b0;
				end
				cap_q[idx] <= BUF_VAL;
				cnt_q[idx] <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s2 <= action_c;
			res_s2    <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = action_s2;
	assign m_tdata  = pfcc_pkg::M_TDATA_W'(res_s2);

endmodule

FILE: rtl/pfcc_checker.sv
module pfcc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pfcc_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);

	// a waiting result holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// backpressure on the input only when a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting result");

	// report fields other than the frame count stay zero unless the frame completed
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pfcc_pkg::ACT_DONE |->
			m_tdata[25:0] == '0 && m_tdata[65:58] == '0)
		else $error("frame report on a non-completion result");

	// RGBW classification needs a byte count divisible by four
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25] |-> m_tdata[2:1] == 2'b00 && m_tdata[13:1] != '0)
		else $error("RGBW flagged on a count not divisible by four");

endmodule

bind pixel_frame_capture_control pfcc_checker u_pfcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int NUM_CHANNELS = 4;
	localparam int BUF_BYTES    = 4096;
	localparam int MAX_COUNT    = (1 << pfcc_pkg::COUNT_W) - 1;
	localparam logic [pfcc_pkg::MASK_W-1:0] FEED_BITS =
		(pfcc_pkg::FEEDS >= pfcc_pkg::MASK_W) ? {pfcc_pkg::MASK_W{1'b1}}
			: pfcc_pkg::MASK_W'((1 << pfcc_pkg::FEEDS) - 1);
	// Feed mask registers sit in channel order
	localparam int REG_FEED_MASK_CH0 = 0;
	localparam int REPORT_W = $bits(pfcc_pkg::out_item_t);

	// Receiver stall patterns
	localparam int RX_ALWAYS = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_STARVE = 2;
	localparam int RX_TOGGLE = 3;

	typedef struct {
		pfcc_pkg::action_t   act;
		pfcc_pkg::out_item_t rep;
	} frame_report_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [pfcc_pkg::S_TDATA_W-1:0] s_tdata;
	logic [pfcc_pkg::CHAN_W-1:0]    s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [pfcc_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;
	logic                           cfg_we;
	logic [pfcc_pkg::REG_IDX_W-1:0] cfg_index;
	logic [pfcc_pkg::MASK_W-1:0]    cfg_data;

	// Predicted per-channel state
	logic [pfcc_pkg::MASK_W-1:0]   feed_mask   [NUM_CHANNELS];
	logic                          abort_flag  [NUM_CHANNELS];
	logic [pfcc_pkg::COUNT_W-1:0]  held_bytes  [NUM_CHANNELS];
	logic [pfcc_pkg::FRAMES_W-1:0] frame_total [NUM_CHANNELS];

	frame_report_t pending_reports[$];
	int errors     = 0;
	int burst_left = 0;
	int sent_count = 0;
	int ready_mode = RX_ALWAYS;
	int ready_left = 0;

	pixel_frame_capture_control #(
		.BUFFER_BYTES(BUF_BYTES),
		.CHANNELS    (NUM_CHANNELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function automatic frame_report_t capture_decision(logic [pfcc_pkg::CHAN_W-1:0] chan,
			logic busy, logic empty, logic [pfcc_pkg::COUNT_W-1:0] count);
		frame_report_t r;
		logic [pfcc_pkg::COUNT_W-1:0] third;
		r.act = pfcc_pkg::ACT_WAIT;
		r.rep = '0;
		if (chan < NUM_CHANNELS) begin
			if (busy) begin
				if (empty && !abort_flag[chan]) begin
					if (count == '0) begin
						r.act = pfcc_pkg::ACT_SPURIOUS;
					end else begin
						held_bytes[chan] = (count > BUF_BYTES)
							? pfcc_pkg::COUNT_W'(BUF_BYTES) : count;
						abort_flag[chan] = 1'b1;
						r.act = pfcc_pkg::ACT_ABORT;
					end
				end
			end else begin
				// a pending abort survives a flush
				if (empty)
					abort_flag[chan] = 1'b0;
				else
					r.rep.fifo_flushed = 1'b1;
				r.act = pfcc_pkg::ACT_DONE;
				r.rep.frame_bytes = held_bytes[chan];
				held_bytes[chan] = pfcc_pkg::COUNT_W'(BUF_BYTES);
				third = pfcc_pkg::COUNT_W'(r.rep.frame_bytes / 3);
				if (r.rep.frame_bytes % 3 == 0) begin
					r.rep.frame_pixels = pfcc_pkg::PIXEL_W'(third);
				end else if (r.rep.frame_bytes[1:0] == 2'b00) begin
					r.rep.frame_pixels = pfcc_pkg::PIXEL_W'(r.rep.frame_bytes >> 2);
					r.rep.is_rgbw = 1'b1;
				end else begin
					r.rep.frame_pixels = pfcc_pkg::PIXEL_W'(third);
				end
				frame_total[chan] = frame_total[chan] + 32'd1;
				r.rep.feed_trigger = feed_mask[chan] & FEED_BITS;
			end
			r.rep.frames_done = frame_total[chan];
		end
		return r;
	endfunction

	function automatic logic [pfcc_pkg::COUNT_W-1:0] pick_byte_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return pfcc_pkg::COUNT_W'(BUF_BYTES);
			2: return pfcc_pkg::COUNT_W'($urandom_range(BUF_BYTES + 1, MAX_COUNT));
			3, 4: return pfcc_pkg::COUNT_W'($urandom_range(1, 48));
			5: return pfcc_pkg::COUNT_W'($urandom_range(0, MAX_COUNT));
			default: return pfcc_pkg::COUNT_W'($urandom_range(1, BUF_BYTES - 1));
		endcase
	endfunction

	task automatic send_event(logic [pfcc_pkg::CHAN_W-1:0] chan, logic busy, logic empty,
			logic [pfcc_pkg::COUNT_W-1:0] count);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 12);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= chan;
		s_tdata  <= {1'b0, count, empty, busy};
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(capture_decision(chan, busy, empty, count));
		burst_left--;
		sent_count++;
	endtask

	task automatic write_feed_mask(int chan, logic [pfcc_pkg::MASK_W-1:0] mask);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= pfcc_pkg::REG_IDX_W'(REG_FEED_MASK_CH0 + chan);
		cfg_data  <= mask;
		@(negedge clk);
		cfg_we <= 1'b0;
		feed_mask[chan] = mask;
	endtask

	// Drop valid and wait out every outstanding request plus the pipeline
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		frame_report_t want;
		pfcc_pkg::out_item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = pfcc_pkg::out_item_t'(m_tdata[REPORT_W-1:0]);
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual action %0d",
					$time, m_tuser);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("action", 32'(want.act), 32'(m_tuser));
				check_field("fifo_flushed", 32'(want.rep.fifo_flushed),
					32'(got.fifo_flushed));
				check_field("frame_bytes", 32'(want.rep.frame_bytes), 32'(got.frame_bytes));
				check_field("frame_pixels", 32'(want.rep.frame_pixels),
					32'(got.frame_pixels));
				check_field("is_rgbw", 32'(want.rep.is_rgbw), 32'(got.is_rgbw));
				check_field("frames_done", want.rep.frames_done, got.frames_done);
				check_field("feed_trigger", 32'(want.rep.feed_trigger),
					32'(got.feed_trigger));
				check_field("tdata pad", 32'd0, 32'(m_tdata[pfcc_pkg::M_TDATA_W-1:REPORT_W]));
			end
		end
	end

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(RX_ALWAYS, RX_TOGGLE);
			ready_left = $urandom_range(8, 60);
		end
		ready_left--;
		case (ready_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_STARVE: m_tready <= ($urandom_range(0, 7) == 0);
			default:   m_tready <= ~m_tready;
		endcase
	end

	// Completion straight after reset reports the full buffer on each channel
	task automatic test_reset_defaults();
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_event(pfcc_pkg::CHAN_W'(c), 1'b0, 1'b1, '0);
		send_event(pfcc_pkg::CHAN_W'(0), 1'b1, 1'b1, '0);
	endtask

	task automatic test_actions();
		send_event(pfcc_pkg::CHAN_W'(1), 1'b1, 1'b0, pfcc_pkg::COUNT_W'(MAX_COUNT));
		send_event(pfcc_pkg::CHAN_W'(1), 1'b1, 1'b1, '0);
		send_event(pfcc_pkg::CHAN_W'(1), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(100));
		send_event(pfcc_pkg::CHAN_W'(1), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(555));
		send_event(pfcc_pkg::CHAN_W'(1), 1'b0, 1'b1, '0);
	endtask

	// Divisible by both, by neither, and an oversized count
	task automatic test_byte_classes();
		send_event(pfcc_pkg::CHAN_W'(2), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(12));
		send_event(pfcc_pkg::CHAN_W'(2), 1'b0, 1'b1, '0);
		send_event(pfcc_pkg::CHAN_W'(2), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(7));
		send_event(pfcc_pkg::CHAN_W'(2), 1'b0, 1'b1, '0);
		send_event(pfcc_pkg::CHAN_W'(2), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(MAX_COUNT));
		send_event(pfcc_pkg::CHAN_W'(2), 1'b0, 1'b1, '0);
	endtask

	// Flush keeps the abort pending until a completion with the FIFO empty
	task automatic test_flush_with_abort();
		send_event(pfcc_pkg::CHAN_W'(3), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(1));
		send_event(pfcc_pkg::CHAN_W'(3), 1'b0, 1'b0, pfcc_pkg::COUNT_W'(9));
		send_event(pfcc_pkg::CHAN_W'(3), 1'b1, 1'b1, pfcc_pkg::COUNT_W'(50));
		send_event(pfcc_pkg::CHAN_W'(3), 1'b0, 1'b1, '0);
	endtask

	task automatic test_feed_masks();
		settle();
		write_feed_mask(0, 8'hFF);
		write_feed_mask(1, 8'h00);
		write_feed_mask(2, 8'hA5);
		write_feed_mask(3, 8'h5A);
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_event(pfcc_pkg::CHAN_W'(c), 1'b0, 1'($urandom_range(0, 1)),
				pick_byte_count());
	endtask

	task automatic run_frame(logic [pfcc_pkg::CHAN_W-1:0] chan);
		int n;
		n = $urandom_range(0, 3);
		repeat (n) send_event(chan, 1'b1, 1'b0, pick_byte_count());
		if ($urandom_range(0, 9) == 0)
			send_event(chan, 1'b1, 1'b1, '0);
		send_event(chan, 1'b1, 1'b1, pick_byte_count());
		n = $urandom_range(0, 2);
		repeat (n) send_event(chan, 1'b1, 1'($urandom_range(0, 1)), pick_byte_count());
		send_event(chan, 1'b0, ($urandom_range(0, 3) != 0), pick_byte_count());
	endtask

	task automatic test_random_traffic();
		int issued;
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				case ($urandom_range(0, 3))
					0: write_feed_mask(c, 8'h00);
					1: write_feed_mask(c, 8'hFF);
					default: write_feed_mask(c, pfcc_pkg::MASK_W'($urandom_range(0, 255)));
				endcase
			end
			issued = 0;
			while (issued < 85) begin
				if ($urandom_range(0, 9) < 7) begin
					// count the frame by the requests it sent
					issued -= sent_count;
					run_frame(pfcc_pkg::CHAN_W'($urandom_range(0, NUM_CHANNELS - 1)));
					issued += sent_count;
				end else begin
					send_event(pfcc_pkg::CHAN_W'($urandom_range(0, NUM_CHANNELS - 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						pfcc_pkg::COUNT_W'($urandom_range(0, MAX_COUNT)));
					issued++;
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			feed_mask[c]   = '0;
			abort_flag[c]  = 1'b0;
			held_bytes[c]  = pfcc_pkg::COUNT_W'(BUF_BYTES);
			frame_total[c] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_actions();
		test_byte_classes();
		test_flush_with_abort();
		test_feed_masks();
		test_random_traffic();
		settle();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pfcc_pkg.sv
rtl/pixel_frame_capture_control.sv
rtl/pfcc_checker.sv
tb/testbench.sv
